>>> hdl/gpsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpsu_pkg
// Shared types, codes and the colour quantiser for the 2bpp plane split unit.
// ----------------------------------------------------------------------------
package gpsu_pkg;

   localparam int X_W     = 9;
   localparam int Y_W     = 9;
   localparam int COL_W   = 8;
   localparam int COLB_W  = 6;
   localparam int MODE_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int SUM_W   = 10;

   localparam logic [MODE_W-1:0] MODE_DRAW = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FILL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

   localparam logic [SUM_W-1:0] THR_LO  = 10'd192;
   localparam logic [SUM_W-1:0] THR_MID = 10'd384;
   localparam logic [SUM_W-1:0] THR_HI  = 10'd576;

   localparam logic [1:0] LVL_MASK = 2'h3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DRAW_CALC,
      ST_DRAW_RD,
      ST_DRAW_WR,
      ST_FILL,
      ST_READ_CALC,
      ST_READ_RD0,
      ST_READ_RD1,
      ST_READ_RD2,
      ST_READ_RD3,
      ST_READ_DONE
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       calc;
      logic       calc_draw;
      logic       draw_wr;
      logic       win_rd;
      logic [1:0] win_off;
      logic       win_shift;
      logic       fill_wr;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic in_frame;
      logic fill_last;
      logic fill_zero;
      logic rsp_free;
   } status_type;

   function automatic logic [1:0] gray_level(input logic [COL_W-1:0] r,
                                             input logic [COL_W-1:0] g,
                                             input logic [COL_W-1:0] b);
      logic [SUM_W-1:0] s;
      logic [1:0]       lvl;
      s = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
      if (s < THR_LO) begin
         lvl = 2'd0;
      end else if (s < THR_MID) begin
         lvl = 2'd2;
      end else if (s < THR_HI) begin
         lvl = 2'd1;
      end else begin
         lvl = 2'd3;
      end
      return lvl;
   endfunction

endpackage
`default_nettype wire

>>> hdl/gpsu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpsu_ctrl
// Sequencer for draw, fill and plane read requests; drives the datapath.
// ----------------------------------------------------------------------------
module gpsu_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [gpsu_pkg::MODE_W-1:0]   req_mode,
   input  wire gpsu_pkg::status_type          st,
   output      gpsu_pkg::cmd_type             cmd
);
   import gpsu_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               case (req_mode)
                  MODE_DRAW: state_in = ST_DRAW_CALC;
                  MODE_FILL: state_in = ST_FILL;
                  MODE_READ: state_in = ST_READ_CALC;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_DRAW_CALC: begin
            cmd.calc      = 1'b1;
            cmd.calc_draw = 1'b1;
            state_in      = ST_DRAW_RD;
         end
         ST_DRAW_RD: begin
            state_in = st.in_frame ? ST_DRAW_WR : ST_IDLE;
         end
         ST_DRAW_WR: begin
            cmd.draw_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_FILL: begin
            cmd.fill_wr = 1'b1;
            if (st.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_READ_RD0;
         end
         ST_READ_RD0: begin
            cmd.win_rd  = 1'b1;
            cmd.win_off = 2'd0;
            state_in    = ST_READ_RD1;
         end
         ST_READ_RD1: begin
            cmd.win_rd    = 1'b1;
            cmd.win_off   = 2'd1;
            cmd.win_shift = 1'b1;
            state_in      = ST_READ_RD2;
         end
         ST_READ_RD2: begin
            cmd.win_rd    = 1'b1;
            cmd.win_off   = 2'd2;
            cmd.win_shift = 1'b1;
            state_in      = ST_READ_RD3;
         end
         ST_READ_RD3: begin
            cmd.win_shift = 1'b1;
            state_in      = ST_READ_DONE;
         end
         ST_READ_DONE: begin
            if (st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hdl/gpsu_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpsu_datapath
// Frame store, address arithmetic, read-modify-write and plane extraction.
// ----------------------------------------------------------------------------
module gpsu_datapath #(
   parameter int WIDTH  = 400,
   parameter int HEIGHT = 300
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gpsu_pkg::cmd_type             cmd,
   output      gpsu_pkg::status_type          st,
   input  wire logic [gpsu_pkg::X_W-1:0]      req_x,
   input  wire logic [gpsu_pkg::Y_W-1:0]      req_y,
   input  wire logic [gpsu_pkg::COL_W-1:0]    req_red,
   input  wire logic [gpsu_pkg::COL_W-1:0]    req_green,
   input  wire logic [gpsu_pkg::COL_W-1:0]    req_blue,
   input  wire logic                          req_plane,
   input  wire logic [gpsu_pkg::COLB_W-1:0]   req_column_byte,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [gpsu_pkg::BYTE_W-1:0]   rsp_plane_byte
);
   import gpsu_pkg::*;

   localparam int NPIX    = WIDTH * HEIGHT;
   localparam int NBYTES  = (NPIX + 3) / 4;
   localparam int ADDR_W  = $clog2(NBYTES);
   localparam int BASE_W  = $clog2(((1 << Y_W) - 1) * WIDTH + (1 << X_W));
   localparam int CMP_W   = BASE_W + 1;
   localparam int WADDR_W = BASE_W - 1;

   logic [X_W-1:0]    x_ff;
   logic [Y_W-1:0]    y_ff;
   logic [COL_W-1:0]  red_ff;
   logic [COL_W-1:0]  green_ff;
   logic [COL_W-1:0]  blue_ff;
   logic              plane_ff;
   logic [COLB_W-1:0] colb_ff;

   logic [BASE_W-1:0] base_ff;
   logic [BASE_W-1:0] base_in;
   logic              in_frame_ff;
   logic              in_frame_in;

   logic [BYTE_W-1:0] mem [NBYTES];
   logic [BYTE_W-1:0] q_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              wr_en;
   logic [WADDR_W-1:0] win_addr;

   logic [ADDR_W-1:0] fill_ptr_ff;
   logic [ADDR_W-1:0] fill_ptr_in;

   logic [3*BYTE_W-1:0] win_ff;
   logic [3*BYTE_W-1:0] win_al;

   logic [1:0]        lvl;
   logic [BYTE_W-1:0] fill_byte;
   logic [BYTE_W-1:0] draw_byte;
   logic [2:0]        sh;
   logic [CMP_W-1:0]  rem;
   logic [BYTE_W-1:0] plane_byte;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff     <= req_x;
         y_ff     <= req_y;
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         plane_ff <= req_plane;
         colb_ff  <= req_column_byte;
      end
   end

   // pixel index for draw, first pixel of the plane group for read
   always_comb begin
      base_in = BASE_W'(BASE_W'(y_ff) * BASE_W'(WIDTH))
              + (cmd.calc_draw ? BASE_W'(x_ff) : BASE_W'({colb_ff, 3'b000}));
      in_frame_in = (32'(x_ff) < 32'(WIDTH)) && (32'(y_ff) < 32'(HEIGHT));
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         base_ff     <= base_in;
         in_frame_ff <= in_frame_in;
      end
   end

   assign lvl       = gray_level(red_ff, green_ff, blue_ff);
   assign fill_byte = {lvl, lvl, lvl, lvl};
   assign sh        = 3'd6 - {base_ff[1:0], 1'b0};
   assign draw_byte = (q_ff & ~(BYTE_W'(LVL_MASK) << sh)) | (BYTE_W'(lvl) << sh);

   assign win_addr = WADDR_W'(base_ff[BASE_W-1:2]) + WADDR_W'(cmd.win_off);
   assign rd_addr  = cmd.win_rd ? win_addr[ADDR_W-1:0] : ADDR_W'(base_ff[BASE_W-1:2]);
   assign wr_addr  = cmd.fill_wr ? fill_ptr_ff : ADDR_W'(base_ff[BASE_W-1:2]);
   assign wr_data  = cmd.fill_wr ? fill_byte : draw_byte;
   assign wr_en    = cmd.fill_wr | cmd.draw_wr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_ff <= mem[rd_addr];
   end

   always_comb begin
      fill_ptr_in = fill_ptr_ff;
      if (cmd.fill_wr) begin
         fill_ptr_in = st.fill_last ? '0 : fill_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ptr_ff <= '0;
      end else begin
         fill_ptr_ff <= fill_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.win_shift) begin
         win_ff <= {win_ff[2*BYTE_W-1:0], q_ff};
      end
   end

   // pixels at or past the end of the frame read as zero
   always_comb begin
      win_al = win_ff << {base_ff[1:0], 1'b0};
      rem    = (CMP_W'(base_ff) < CMP_W'(NPIX)) ? CMP_W'(NPIX) - CMP_W'(base_ff) : '0;
      for (int k = 0; k < BYTE_W; k++) begin
         plane_byte[BYTE_W-1-k] = win_al[3*BYTE_W-1-2*k-int'(plane_ff)]
                                & (CMP_W'(k) < rem);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= plane_byte;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_plane_byte = rsp_data_ff;

   assign st.in_frame  = in_frame_ff;
   assign st.fill_last = (fill_ptr_ff == ADDR_W'(NBYTES - 1));
   assign st.fill_zero = (fill_ptr_ff == '0);
   assign st.rsp_free  = !rsp_valid_ff || rsp_tready;

endmodule
`default_nettype wire

>>> hdl/gray2bpp_framebuffer_plane_split_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gray2bpp_framebuffer_plane_split_unit
// 4-level grey frame store, 2 bits per pixel, with 1-bit plane readout.
// ----------------------------------------------------------------------------
// Requests arrive on req_ (kind in tuser: draw, fill, plane read); only plane
// reads answer, one byte each on rsp_.
// Draw: multiply, store read and store write per request; out-of-frame draws
//   finish after the store read, without writing.
// Fill: one store byte written per cycle, over all (WIDTH*HEIGHT+3)/4 bytes.
// Plane read: address multiply, three store reads through the single read
//   port, then the result load; the next request is taken after the load.
// The result sits in an output register, so a new request is accepted while
//   it waits; a second read stalls only in its last step until rsp is taken.
// Reset clears the sequencer, the fill pointer and rsp_tvalid. Store contents
//   are undefined until filled or drawn.
// ----------------------------------------------------------------------------
module gray2bpp_framebuffer_plane_split_unit #(
   parameter int WIDTH  = 400,
   parameter int HEIGHT = 300
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // x[8:0], y[17:9], red[25:18], green[33:26], blue[41:34], plane[42],
   // column_byte[48:43], zero[55:49]
   input  wire logic [55:0] req_tdata,
   // mode[1:0]
   input  wire logic [1:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // plane_byte[7:0]
   output      logic [7:0]  rsp_tdata
);
   import gpsu_pkg::*;

   cmd_type    cmd;
   status_type st;

   gpsu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .st         (st),
      .cmd        (cmd)
   );

   gpsu_datapath #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_x           (req_tdata[8:0]),
      .req_y           (req_tdata[17:9]),
      .req_red         (req_tdata[25:18]),
      .req_green       (req_tdata[33:26]),
      .req_blue        (req_tdata[41:34]),
      .req_plane       (req_tdata[42]),
      .req_column_byte (req_tdata[48:43]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_plane_byte  (rsp_tdata)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register loaded while still held");

   a_fill_at_rest: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> st.fill_zero)
      else $error("fill pointer not at rest on acceptance");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == MODE_READ) |=> !req_tready)
      else $error("plane read did not hold off requests");

   a_unknown_drop: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser != MODE_DRAW && req_tuser != MODE_FILL
       && req_tuser != MODE_READ) |=> req_tready)
      else $error("unknown request kind not dropped");

endmodule
`default_nettype wire
